/* sv/crkf_pkg.sv */
`timescale 1ns / 1ps
// shared constants, op codes and saturation helper for the keyframe spline block
package crkf_pkg;

	localparam int MAX_KEYFRAMES_DEF = 64;
	localparam int FRAC_BITS_DEF     = 16;

	localparam int NCOMP   = 11;
	localparam int NSLOT   = 4;
	localparam int DATA_W  = 32;
	localparam int QIDX_W  = 22;
	localparam int IDX_W   = 16;
	localparam int ACC_W   = 40;
	localparam int COUNT_W = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int COMP_TIME = 0;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam acc_t SAT_HI = ACC_W'(64'sd2147483647);
	localparam acc_t SAT_LO = ACC_W'(-64'sd2147483648);

	function automatic word_t sat32(input acc_t x);
		word_t r;
		if (x > SAT_HI) begin
			r = word_t'(SAT_HI);
		end else if (x < SAT_LO) begin
			r = word_t'(SAT_LO);
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/crkf_bank.sv */
`timescale 1ns / 1ps
// one component bank: single write port, one registered read port
module crkf_bank import crkf_pkg::*; #(
	parameter int DEPTH = MAX_KEYFRAMES_DEF,
	parameter int AW    = $clog2(MAX_KEYFRAMES_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output word_t         rdata
);

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/crkf_lane.sv */
`timescale 1ns / 1ps
// catmull-rom lane for one component, horner form, stages s2 to s8
module crkf_lane import crkf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic                 bypass_s1,
	input  logic [FRAC_BITS-1:0] u_s1,
	input  word_t                p0_s1,
	input  word_t                p1_s1,
	input  word_t                p2_s1,
	input  word_t                p3_s1,
	output word_t                res_s8
);

	localparam int PW = ACC_W + FRAC_BITS + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	function automatic acc_t rnd(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] t;
		t = (x + HALF) >>> FRAC_BITS;
		return t[ACC_W-1:0];
	endfunction

	acc_t e0, e1, e2, e3, d12;
	acc_t a_s2, b_s2, c_s2, a_s3, b_s3, a_s4, a_s5, acc_s4, acc_s6;
	logic signed [PW-1:0] m_s3, m_s5, m_s7;
	logic signed [FRAC_BITS:0] us_s2, us_s3, us_s4, us_s5, us_s6;
	word_t p1_s2, p1_s3, p1_s4, p1_s5, p1_s6, p1_s7;
	logic byp_s2, byp_s3, byp_s4, byp_s5, byp_s6, byp_s7;
	acc_t acc3, fin;

	always_comb begin
		e0  = ACC_W'(p0_s1);
		e1  = ACC_W'(p1_s1);
		e2  = ACC_W'(p2_s1);
		e3  = ACC_W'(p3_s1);
		d12 = e1 - e2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// coefficients
			a_s2   <= e2 - e0;
			b_s2   <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
			c_s2   <= e3 - e0 + (d12 <<< 1) + d12;
			us_s2  <= {1'b0, u_s1};
			p1_s2  <= p1_s1;
			byp_s2 <= bypass_s1;
			// c * u
			m_s3   <= c_s2 * us_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			us_s3  <= us_s2;
			p1_s3  <= p1_s2;
			byp_s3 <= byp_s2;
			// + b
			acc_s4 <= rnd(m_s3) + b_s3;
			a_s4   <= a_s3;
			us_s4  <= us_s3;
			p1_s4  <= p1_s3;
			byp_s4 <= byp_s3;
			// * u
			m_s5   <= acc_s4 * us_s4;
			a_s5   <= a_s4;
			us_s5  <= us_s4;
			p1_s5  <= p1_s4;
			byp_s5 <= byp_s4;
			// + a
			acc_s6 <= rnd(m_s5) + a_s5;
			us_s6  <= us_s5;
			p1_s6  <= p1_s5;
			byp_s6 <= byp_s5;
			// * u
			m_s7   <= acc_s6 * us_s6;
			p1_s7  <= p1_s6;
			byp_s7 <= byp_s6;
			// + 2 p1, halve, saturate
			res_s8 <= byp_s7 ? p1_s7 : sat32(fin);
		end
	end

	always_comb begin
		acc3 = rnd(m_s7) + (ACC_W'(p1_s7) <<< 1);
		fin  = (acc3 + ACC_W'(1)) >>> 1;
	end

endmodule

/* sv/crkf_lerp.sv */
`timescale 1ns / 1ps
// linear time lane, result ready at s4 and delayed to s8
module crkf_lerp import crkf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic                 bypass_s1,
	input  logic [FRAC_BITS-1:0] u_s1,
	input  word_t                t1_s1,
	input  word_t                t2_s1,
	output word_t                res_s8
);

	localparam int PW = ACC_W + FRAC_BITS + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	function automatic acc_t rnd(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] t;
		t = (x + HALF) >>> FRAC_BITS;
		return t[ACC_W-1:0];
	endfunction

	acc_t d_s2;
	logic signed [FRAC_BITS:0] us_s2;
	logic signed [PW-1:0] m_s3;
	word_t t1_s2, t1_s3, r_s4, r_s5, r_s6, r_s7;
	logic byp_s2, byp_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= ACC_W'(t2_s1) - ACC_W'(t1_s1);
			us_s2  <= {1'b0, u_s1};
			t1_s2  <= t1_s1;
			byp_s2 <= bypass_s1;
			m_s3   <= d_s2 * us_s2;
			t1_s3  <= t1_s2;
			byp_s3 <= byp_s2;
			r_s4   <= byp_s3 ? t1_s3 : sat32(ACC_W'(t1_s3) + rnd(m_s3));
			r_s5   <= r_s4;
			r_s6   <= r_s5;
			r_s7   <= r_s6;
			res_s8 <= r_s7;
		end
	end

endmodule

/* sv/camera_keyframe_spline_interp_top.sv */
`timescale 1ns / 1ps
// top level: keyframe table banks, index decode, valid pipeline and lanes
//
// keyframe table with catmull-rom interpolation. a write word (op 0) stores
// one component of one entry; a query word (op 1) returns one result word.
// the block takes one word per clock unless the output stage is stalled:
// the table is held as four copies of eleven component banks, one copy per
// neighbor slot (i-1, i, i+1, i+2), so all 44 reads for a query happen in
// the accept cycle and every write goes to all four copies at once. a
// query reads whatever was written by any earlier accepted write, even the
// one just before it. the datapath is an eight stage pipeline (bank read,
// coefficients, then multiply / round-add pairs of the horner form) and the
// whole pipeline moves together: it stalls only when the last stage holds
// a result word that is not taken. indices at or past count-1, and index
// zero, return entry 0 with clamped set; whole indices return that entry.
// the table has no reset value: query only entries that were written.
module camera_keyframe_spline_interp_top import crkf_pkg::*; #(
	parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [5:0]         entry,
	input  logic [3:0]         component,
	input  word_t              value,
	input  logic [QIDX_W-1:0]  query_index,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic               clamped,
	output word_t              time_out,
	output word_t              pos_x,
	output word_t              pos_y,
	output word_t              pos_z,
	output word_t              look_x,
	output word_t              look_y,
	output word_t              look_z,
	output word_t              up_x,
	output word_t              up_y,
	output word_t              up_z,
	output word_t              aperture
);

	localparam int AW = $clog2(MAX_KEYFRAMES);
	localparam logic [IDX_W-1:0] MAXC = IDX_W'(MAX_KEYFRAMES);

	logic [COUNT_W-1:0] count_q;

	logic adv, accept, wr;
	logic [IDX_W-1:0] kc, cnt, last, ipart, entry_w;
	logic [IDX_W-1:0] i0, i1, i2, i3;
	logic [FRAC_BITS-1:0] frac;
	logic clamp, whole;
	logic [AW-1:0] raddr [NSLOT];
	logic [AW-1:0] waddr;

	word_t rd [NSLOT][NCOMP];
	word_t res [NCOMP];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic clamped_s1, clamped_s2, clamped_s3, clamped_s4;
	logic clamped_s5, clamped_s6, clamped_s7, clamped_s8;
	logic bypass_s1;
	logic [FRAC_BITS-1:0] u_s1;

	// whole pipeline advances unless the output word is stuck
	assign adv      = !vld_s8 || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// index decode in the accept cycle
	always_comb begin
		kc      = IDX_W'(count_q);
		cnt     = (kc == '0) ? IDX_W'(1) : ((kc > MAXC) ? MAXC : kc);
		last    = cnt - IDX_W'(1);
		ipart   = IDX_W'(query_index[QIDX_W-1:FRAC_BITS]);
		frac    = query_index[FRAC_BITS-1:0];
		clamp   = (query_index == '0) || (ipart >= last);
		whole   = (frac == '0);
		i1      = clamp ? '0 : ipart;
		i0      = (ipart == '0) ? '0 : ipart - IDX_W'(1);
		i2      = ipart + IDX_W'(1);
		i3      = ((ipart + IDX_W'(2)) < cnt) ? ipart + IDX_W'(2) : last;
		raddr[0] = i0[AW-1:0];
		raddr[1] = i1[AW-1:0];
		raddr[2] = i2[AW-1:0];
		raddr[3] = i3[AW-1:0];
		entry_w = IDX_W'(entry);
		waddr   = entry_w[AW-1:0];
		wr      = accept && (op == OP_WRITE) && (entry_w < MAXC)
			&& (component < 4'(NCOMP));
	end

	// table copies, one per neighbor slot
	for (genvar s = 0; s < NSLOT; s++) begin : g_slot
		for (genvar c = 0; c < NCOMP; c++) begin : g_comp
			crkf_bank #(
				.DEPTH (MAX_KEYFRAMES),
				.AW    (AW)
			) u_bank (
				.clk   (clk),
				.we    (wr && (component == 4'(c))),
				.waddr (waddr),
				.wdata (value),
				.re    (adv),
				.raddr (raddr[s]),
				.rdata (rd[s][c])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// valid and clamp flags ride along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && (op == OP_QUERY);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clamped_s1 <= clamp;
			bypass_s1  <= clamp || whole;
			u_s1       <= frac;
			clamped_s2 <= clamped_s1;
			clamped_s3 <= clamped_s2;
			clamped_s4 <= clamped_s3;
			clamped_s5 <= clamped_s4;
			clamped_s6 <= clamped_s5;
			clamped_s7 <= clamped_s6;
			clamped_s8 <= clamped_s7;
		end
	end

	// time is linear between the two bracketing entries
	crkf_lerp #(
		.FRAC_BITS (FRAC_BITS)
	) u_lerp (
		.clk       (clk),
		.adv       (adv),
		.bypass_s1 (bypass_s1),
		.u_s1      (u_s1),
		.t1_s1     (rd[1][COMP_TIME]),
		.t2_s1     (rd[2][COMP_TIME]),
		.res_s8    (res[COMP_TIME])
	);

	// every other component goes through its own spline lane
	for (genvar c = 1; c < NCOMP; c++) begin : g_lane
		crkf_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk       (clk),
			.adv       (adv),
			.bypass_s1 (bypass_s1),
			.u_s1      (u_s1),
			.p0_s1     (rd[0][c]),
			.p1_s1     (rd[1][c]),
			.p2_s1     (rd[2][c]),
			.p3_s1     (rd[3][c]),
			.res_s8    (res[c])
		);
	end

	assign out_valid = vld_s8;
	assign clamped   = clamped_s8;
	assign time_out  = res[0];
	assign pos_x     = res[1];
	assign pos_y     = res[2];
	assign pos_z     = res[3];
	assign look_x    = res[4];
	assign look_y    = res[5];
	assign look_z    = res[6];
	assign up_x      = res[7];
	assign up_y      = res[8];
	assign up_z      = res[9];
	assign aperture  = res[10];

	// a write word never enters the result pipeline
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == OP_WRITE) |=> !vld_s1)
		else $error("write word entered result pipeline");

	// a query word always enters the result pipeline
	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == OP_QUERY) |=> vld_s1)
		else $error("query word lost at entry");

	// a stalled pipeline keeps its middle and last stages
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && !out_ready) |=> ($stable(vld_s4) && $stable(clamped_s8)))
		else $error("pipeline moved during stall");

	// a valid query word in s7 moves to s8 when the pipeline advances
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && adv) |=> vld_s8)
		else $error("result dropped before output stage");

endmodule
